FILE: design/epve_pkg.sv
// ----------------------------------------------------------------------------
// epve_pkg
// Shared widths, constants and types of the encoder position/velocity block.
// ----------------------------------------------------------------------------
package epve_pkg;

  localparam int ANGLE_W  = 15;
  localparam int PERIOD_W = 16;
  localparam int TURN_W   = 32;
  localparam int POS_W    = 48;
  localparam int VEL_W    = 32;
  localparam int EVEL_W   = 38;
  localparam int SUM_W    = 38;
  localparam int SMOOTH_W = 54;
  localparam int FRAC_W   = 16;
  localparam int POLE_W   = 7;
  localparam int ALPHA_W  = 16;
  localparam int MOFF_W   = 16;

  localparam int WIN_LEN  = 40;
  localparam int PTR_W    = $clog2(WIN_LEN);

  localparam int DIV_W    = 36;
  localparam int DIV_CYC  = DIV_W / 2;
  localparam int CNT_W    = $clog2(DIV_CYC);

  localparam int MUL_A_W  = ALPHA_W + 1;
  localparam int MUL_B_W  = VEL_W + 1;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int DIFF_W   = SMOOTH_W + 1;
  localparam int LO_W     = 28;
  localparam int HI_W     = DIFF_W - LO_W;
  localparam int ACC_W    = DIFF_W + ALPHA_W;

  localparam int CFG_W    = 16;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 192;

  localparam int HALF_TURN = 1 << (ANGLE_W - 1);
  localparam int FULL_TURN = 1 << ANGLE_W;

  localparam logic [POLE_W-1:0]  POLE_RST  = POLE_W'(7);
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(655);

  typedef enum logic [1:0] {
    REG_MECH_OFFSET,
    REG_ELEC_OFFSET,
    REG_POLE_PAIRS,
    REG_FILTER_ALPHA
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_DIV_VEL,
    ST_WIN,
    ST_AVG_LD,
    ST_DIV_AVG,
    ST_MV,
    ST_EVEL_MUL,
    ST_EVEL,
    ST_DIFF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_FILT,
    ST_OUT
  } state_t;

endpackage

FILE: design/encoder_position_velocity_estimator.sv
// ----------------------------------------------------------------------------
// encoder_position_velocity_estimator
// Multi-turn position, electrical angle and filtered velocity from an
// absolute single-turn angle sensor.
//
// Input item:  tdata = raw_angle[14:0], period_us[30:15].
// Result item: one per input item, held in an output register until taken.
// Config:      cfg_addr selects mech_offset, elec_offset, pole_pairs or
//              filter_alpha; written whenever cfg_valid is high.
// Timing: out_tvalid rises in the same cycle that in_tready returns, so the
// block takes no new item until it is through with the last one. The two
// passes of the shared radix-4 divider (delta/period, window sum/40) make
// up the bulk of the work on each item; one shared 17x33 multiplier does the
// angle, pole-pair and filter products.
// If the receiver stalls, the next item is still accepted and worked on;
// its result waits in the final state until the output register frees up.
// Reset clears turn count, window, filter state and out_tvalid, and restores
// pole_pairs = 7 and filter_alpha = 655. The window clears through per-entry
// valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module encoder_position_velocity_estimator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [epve_pkg::IN_W-1:0]  in_tdata,   // raw_angle, period_us
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [epve_pkg::OUT_W-1:0] out_tdata,  // angle_counts, mech_position,
                                                 // elec_angle, mech_velocity,
                                                 // elec_velocity,
                                                 // elec_velocity_smooth
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  epve_pkg::cfg_reg_t         cfg_addr,
  input  logic [epve_pkg::CFG_W-1:0] cfg_data
);
  import epve_pkg::*;

  // configuration
  logic [MOFF_W-1:0]  mech_offset_r;
  logic [ANGLE_W-1:0] elec_offset_r;
  logic [POLE_W-1:0]  pole_pairs_r;
  logic [ALPHA_W-1:0] alpha_r;

  // persistent state
  logic [ANGLE_W-1:0]       last_angle_r;
  logic [TURN_W-1:0]        turn_r;
  logic [WIN_LEN-1:0]       win_valid_r;
  logic [PTR_W-1:0]         ptr_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [SMOOTH_W-1:0]      s_r;

  // per item working registers
  state_t                     state_r, state_nxt;
  logic [ANGLE_W-1:0]         angle_r;
  logic [PERIOD_W-1:0]        period_r;
  logic [ANGLE_W-1:0]         dmag_r;
  logic                       neg_r;
  logic [POS_W-1:0]           pos_r;
  logic [ANGLE_W-1:0]         elec_r;
  logic signed [VEL_W-1:0]    mv_r;
  logic signed [EVEL_W-1:0]   ev_r;
  logic signed [DIFF_W-1:0]   diff_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [MUL_P_W-1:0]  mul_r;

  // divider
  logic [DIV_W-1:0]    dq_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [PERIOD_W-1:0] dvs_r;
  logic [CNT_W-1:0]    cnt_r;

  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;

  // input fields
  logic [ANGLE_W-1:0]  in_angle;
  logic [PERIOD_W-1:0] in_period;
  assign in_angle  = in_tdata[ANGLE_W-1:0];
  assign in_period = in_tdata[ANGLE_W+PERIOD_W-1:ANGLE_W];

  // ---------------- turn detection ----------------
  logic signed [ANGLE_W+1:0] d_raw, d_wrap;
  logic [TURN_W-1:0]         turn_nxt;
  logic [ANGLE_W-1:0]        dmag_nxt;

  always_comb begin
    d_raw    = $signed({2'b00, in_angle}) - $signed({2'b00, last_angle_r});
    d_wrap   = d_raw;
    turn_nxt = turn_r;
    if (d_raw > $signed((ANGLE_W+2)'(HALF_TURN))) begin
      d_wrap   = d_raw - $signed((ANGLE_W+2)'(FULL_TURN));
      turn_nxt = turn_r - TURN_W'(1);
    end else if (d_raw < -$signed((ANGLE_W+2)'(HALF_TURN))) begin
      d_wrap   = d_raw + $signed((ANGLE_W+2)'(FULL_TURN));
      turn_nxt = turn_r + TURN_W'(1);
    end
    dmag_nxt = d_wrap[ANGLE_W+1] ? ANGLE_W'(-d_wrap) : ANGLE_W'(d_wrap);
  end

  // ---------------- radix-4 divider step ----------------
  logic [PERIOD_W:0]   t1, t2;
  logic                ge1, ge2;
  logic [PERIOD_W-1:0] r1, r2;

  always_comb begin
    t1  = {rem_r, dq_r[DIV_W-1]};
    ge1 = t1 >= {1'b0, dvs_r};
    r1  = ge1 ? PERIOD_W'(t1 - {1'b0, dvs_r}) : t1[PERIOD_W-1:0];
    t2  = {r1, dq_r[DIV_W-2]};
    ge2 = t2 >= {1'b0, dvs_r};
    r2  = ge2 ? PERIOD_W'(t2 - {1'b0, dvs_r}) : t2[PERIOD_W-1:0];
  end

  // ---------------- window RAM ----------------
  logic [VEL_W-1:0]        ram_rdata;
  logic                    ram_we;
  logic signed [VEL_W-1:0] vel_c, old_c;

  assign vel_c = neg_r ? -$signed(dq_r[VEL_W-1:0]) : $signed(dq_r[VEL_W-1:0]);
  assign old_c = win_valid_r[ptr_r] ? $signed(ram_rdata) : '0;

  epve_ram #(
    .WIDTH (VEL_W),
    .DEPTH (WIN_LEN)
  ) u_win (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (vel_c),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // ---------------- shared multiplier operands ----------------
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      out_free;
  logic signed [SUM_W-1:0]   sum_abs;

  assign out_free = !out_valid_r || out_tready;
  assign sum_abs  = sum_r[SUM_W-1] ? -sum_r : sum_r;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_tvalid) state_nxt = ST_POS;
      ST_POS:      state_nxt = ST_DIV_VEL;
      ST_DIV_VEL:  if (cnt_r == CNT_W'(DIV_CYC - 1)) state_nxt = ST_WIN;
      ST_WIN:      state_nxt = ST_AVG_LD;
      ST_AVG_LD:   state_nxt = ST_DIV_AVG;
      ST_DIV_AVG:  if (cnt_r == CNT_W'(DIV_CYC - 1)) state_nxt = ST_MV;
      ST_MV:       state_nxt = ST_EVEL_MUL;
      ST_EVEL_MUL: state_nxt = ST_EVEL;
      ST_EVEL:     state_nxt = ST_DIFF;
      ST_DIFF:     state_nxt = ST_MUL_LO;
      ST_MUL_LO:   state_nxt = ST_MUL_HI;
      ST_MUL_HI:   state_nxt = ST_ACC;
      ST_ACC:      state_nxt = ST_FILT;
      ST_FILT:     state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- state outputs ----------------
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    mul_a     = $signed(MUL_A_W'(pole_pairs_r));
    mul_b     = $signed(MUL_B_W'(in_angle));
    case (state_r)
      ST_IDLE:     in_tready = 1'b1;
      ST_WIN:      ram_we = 1'b1;
      ST_EVEL_MUL: mul_b = MUL_B_W'(mv_r);
      ST_MUL_LO: begin
        mul_a = $signed(MUL_A_W'(alpha_r));
        mul_b = $signed(MUL_B_W'(diff_r[LO_W-1:0]));
      end
      ST_MUL_HI: begin
        mul_a = $signed(MUL_A_W'(alpha_r));
        mul_b = MUL_B_W'($signed(diff_r[DIFF_W-1:LO_W]));
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      mech_offset_r <= '0;
      elec_offset_r <= '0;
      pole_pairs_r  <= POLE_RST;
      alpha_r       <= ALPHA_RST;
      last_angle_r  <= '0;
      turn_r        <= '0;
      win_valid_r   <= '0;
      ptr_r         <= '0;
      sum_r         <= '0;
      s_r           <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_addr)
          REG_MECH_OFFSET:  mech_offset_r <= cfg_data[MOFF_W-1:0];
          REG_ELEC_OFFSET:  elec_offset_r <= cfg_data[ANGLE_W-1:0];
          REG_POLE_PAIRS:   pole_pairs_r  <= cfg_data[POLE_W-1:0];
          REG_FILTER_ALPHA: alpha_r       <= cfg_data[ALPHA_W-1:0];
          default: begin
          end
        endcase
      end
      if (state_r == ST_IDLE && in_tvalid) begin
        last_angle_r <= in_angle;
        turn_r       <= turn_nxt;
      end
      if (state_r == ST_WIN) begin
        sum_r              <= sum_r + SUM_W'(vel_c) - SUM_W'(old_c);
        win_valid_r[ptr_r] <= 1'b1;
        ptr_r              <= (ptr_r == PTR_W'(WIN_LEN - 1)) ? '0 : ptr_r + PTR_W'(1);
      end
      if (state_r == ST_FILT) begin
        s_r <= s_r + acc_r[SMOOTH_W+FRAC_W-1:FRAC_W];
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        angle_r  <= in_angle;
        period_r <= (in_period == '0) ? PERIOD_W'(1) : in_period;
        dmag_r   <= dmag_nxt;
        neg_r    <= d_wrap[ANGLE_W+1];
      end
      ST_POS: begin
        pos_r  <= {1'b0, turn_r, angle_r} - POS_W'($signed(mech_offset_r));
        elec_r <= mul_r[ANGLE_W-1:0] + elec_offset_r;
        dq_r   <= DIV_W'({dmag_r, FRAC_W'(0)});
        rem_r  <= '0;
        dvs_r  <= period_r;
        cnt_r  <= '0;
      end
      ST_DIV_VEL, ST_DIV_AVG: begin
        dq_r  <= {dq_r[DIV_W-3:0], ge1, ge2};
        rem_r <= r2;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      ST_AVG_LD: begin
        neg_r <= sum_r[SUM_W-1];
        dq_r  <= sum_abs[DIV_W-1:0];
        rem_r <= '0;
        dvs_r <= PERIOD_W'(WIN_LEN);
        cnt_r <= '0;
      end
      ST_MV: mv_r <= vel_c;
      ST_EVEL: begin
        if (mul_r[MUL_P_W-1:EVEL_W-1] == '0 || mul_r[MUL_P_W-1:EVEL_W-1] == '1) begin
          ev_r <= mul_r[EVEL_W-1:0];
        end else begin
          ev_r <= {mul_r[MUL_P_W-1], {(EVEL_W-1){~mul_r[MUL_P_W-1]}}};
        end
      end
      ST_DIFF: diff_r <= $signed({ev_r[EVEL_W-1], ev_r, FRAC_W'(0)})
                         - $signed({s_r[SMOOTH_W-1], s_r});
      ST_MUL_HI: acc_r <= ACC_W'(mul_r);
      ST_ACC: acc_r <= acc_r + $signed({mul_r[ACC_W-LO_W-1:0], LO_W'(0)});
      ST_OUT: begin
        if (out_free) begin
          out_data_r <= {6'b0,
                         s_r[SMOOTH_W-1:FRAC_W],
                         ev_r,
                         mv_r,
                         elec_r,
                         pos_r,
                         angle_r};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: design/epve_ram.sv
// ----------------------------------------------------------------------------
// epve_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module epve_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/epve_checker.sv
// ----------------------------------------------------------------------------
// epve_assertions
// Port-level checks of the encoder position/velocity block, bound to the top.
// ----------------------------------------------------------------------------
module epve_assertions (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [epve_pkg::OUT_W-1:0] out_tdata
);

  // one item at a time: no new item right after one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high right after an item was accepted");

  // a result never shows up the cycle after an item is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared one cycle after accept");

  // a result item is held stable while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result item changed");

  // reset drops the output
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule

bind encoder_position_velocity_estimator epve_assertions u_epve_assertions (.*);
